[hw/rtl/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
`default_nettype none

package spq_pkg;

	// Width of a priority number.
	localparam int PRIO_W = 8;

	// Request actions.
	localparam logic [1:0] ACT_ENQ  = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;

	// Response status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Shift command broadcast to every cell of the row.
	typedef struct packed {
		logic enq;
		logic pop;
	} spq_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// One storage cell of the sorted shift-register row.
`default_nettype none

module spq_cell
	import spq_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire spq_ctl_t              ctl,
	input  wire logic                  occ,
	input  wire logic [PRIO_W-1:0]     new_prio,
	input  wire logic [DATA_WIDTH-1:0] new_data,
	input  wire logic                  prev_after,
	input  wire logic [PRIO_W-1:0]     prev_prio,
	input  wire logic [DATA_WIDTH-1:0] prev_data,
	input  wire logic [PRIO_W-1:0]     next_prio,
	input  wire logic [DATA_WIDTH-1:0] next_data,
	output logic                       after,
	output logic [PRIO_W-1:0]          prio_q,
	output logic [DATA_WIDTH-1:0]      data_q
);

	// The new word goes behind this cell when the cell holds an entry that is not worse.
	assign after = occ && (prio_q <= new_prio);

	// Keep, take the new word, take the left neighbor on insert, or the right one on pop.
	always_ff @(posedge clk) begin
		if (ctl.enq && !after) begin
			if (prev_after) begin
				prio_q <= new_prio;
				data_q <= new_data;
			end else begin
				prio_q <= prev_prio;
				data_q <= prev_data;
			end
		end else if (ctl.pop) begin
			prio_q <= next_prio;
			data_q <= next_data;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/stable_priority_queue.sv]
// Top level of the stable priority queue: a sorted row of shift cells and the response register.
//
//   Channel   Handshake               Word
//   request   req_valid / req_ready   action, prio, data_word
//   response  rsp_valid / rsp_ready   head_data, head_valid, status, entry_count
//
// Each request word is resolved by the whole row: every cell compares its own priority with
// the new one and shifts in parallel; one request is taken per clock while req_ready is high.
// The response sits in an output register; a new request is taken while that register is
// empty or being read in the same cycle, so a stalled response holds off only the next word.
// Reset clears the entry count and the response valid; cell contents need no reset.
`default_nettype none

module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [1:0]                    action,
	input  wire logic [PRIO_W-1:0]             prio,
	input  wire logic [DATA_WIDTH-1:0]         data_word,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic [DATA_WIDTH-1:0]              head_data,
	output logic                               head_valid,
	output logic [1:0]                         status,
	output logic [$clog2(DEPTH+1)-1:0]         entry_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                  rsp_valid_q;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] head_data_q;
	logic                  head_valid_q;
	logic [1:0]            status_q;

	logic                  acc;
	logic                  full;
	logic                  empty;
	spq_ctl_t              ctl;
	logic [CNT_W-1:0]      count_nxt;
	logic [DATA_WIDTH-1:0] hdata_nxt;
	logic                  hvalid_nxt;
	logic [1:0]            status_nxt;

	logic [DEPTH-1:0]      occ;
	logic [DEPTH-1:0]      after;
	logic [PRIO_W-1:0]     cell_prio [DEPTH];
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	// Handshake: take a word whenever the response register is free or draining.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// Decode the action into the shift command and the response fields.
	always_comb begin
		ctl        = '0;
		count_nxt  = count_q;
		hdata_nxt  = '0;
		hvalid_nxt = 1'b0;
		status_nxt = ST_OK;
		unique case (action) inside
			ACT_ENQ: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.enq   = acc;
					count_nxt = count_q + 1'b1;
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					hdata_nxt  = cell_data[0];
					hvalid_nxt = 1'b1;
					if (action == ACT_POP) begin
						ctl.pop   = acc;
						count_nxt = count_q - 1'b1;
					end
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	// Row of cells, slot zero at the head.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  prev_after;
		logic [PRIO_W-1:0]     prev_prio;
		logic [DATA_WIDTH-1:0] prev_data;
		logic [PRIO_W-1:0]     next_prio;
		logic [DATA_WIDTH-1:0] next_data;

		assign occ[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign prev_after = 1'b1;
			assign prev_prio  = prio;
			assign prev_data  = data_word;
		end else begin : g_body
			assign prev_after = after[i-1];
			assign prev_prio  = cell_prio[i-1];
			assign prev_data  = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_prio = '0;
			assign next_data = '0;
		end else begin : g_link
			assign next_prio = cell_prio[i+1];
			assign next_data = cell_data[i+1];
		end

		spq_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ[i]),
			.new_prio   (prio),
			.new_data   (data_word),
			.prev_after (prev_after),
			.prev_prio  (prev_prio),
			.prev_data  (prev_data),
			.next_prio  (next_prio),
			.next_data  (next_data),
			.after      (after[i]),
			.prio_q     (cell_prio[i]),
			.data_q     (cell_data[i])
		);
	end

	// Entry count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			head_data_q  <= hdata_nxt;
			head_valid_q <= hvalid_nxt;
			status_q     <= status_nxt;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign head_data   = head_data_q;
	assign head_valid  = head_valid_q;
	assign status      = status_q;
	assign entry_count = count_q;

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// A pop on a non-empty queue removes exactly one entry.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && action == ACT_POP && !empty) |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not remove one entry");

	// A returned head always comes with an ok status.
	a_head_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && head_valid_q) |-> status_q == ST_OK)
		else $error("head word with a failing status");

	// The two front cells stay in priority order.
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> cell_prio[0] <= cell_prio[1])
		else $error("front cells out of order");

endmodule

`default_nettype wire
